FILE: rtl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg
// shared types, codes and constants of the hashed memo table
// ----------------------------------------------------------------------------
package hmt_pkg;

    localparam int DEF_MAX_INDEX_BITS = 8;
    localparam int DEF_WAYS           = 4;

    localparam int HASH_W  = 32;
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int STAMP_W = 32;
    localparam int HITS_W  = 32;
    localparam int RANK_W  = 4;   // covers up to sixteen ways
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_EVICTED  = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    localparam logic [1:0] MODE_NEVER = 2'd0;
    localparam logic [1:0] MODE_FIFO  = 2'd1;
    localparam logic [1:0] MODE_LRU   = 2'd2;
    localparam logic [1:0] MODE_LFU   = 2'd3;

    localparam logic [1:0] REG_REPLACE_MODE = 2'd0;
    localparam logic [1:0] REG_WAYS_IN_USE  = 2'd1;
    localparam logic [1:0] REG_INDEX_BITS   = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CALC,
        FSM_WRITE
    } fsm_t;

    typedef struct packed {
        logic                 valid;
        logic [HASH_W-1:0]    hash;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        logic [STAMP_W-1:0]   last_use;
        logic [HITS_W-1:0]    hits;
        logic [RANK_W-1:0]    rank;
    } entry_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   read_value;
    } result_t;

endpackage

FILE: rtl/hmt_ram.sv
// ----------------------------------------------------------------------------
// hmt_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module hmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/hmt_set_logic.sv
// ----------------------------------------------------------------------------
// hmt_set_logic
// match, victim choice and row update for one set
// ----------------------------------------------------------------------------
module hmt_set_logic #(
    parameter int WAYS = 4
) (
    input  hmt_pkg::entry_t [WAYS-1:0]       row_in,
    input  logic                             row_ok,
    input  hmt_pkg::opcode_t                 opcode,
    input  logic [hmt_pkg::HASH_W-1:0]       key_hash,
    input  logic [hmt_pkg::KEY_W-1:0]        key_word,
    input  logic [hmt_pkg::VALUE_W-1:0]      store_value,
    input  logic [hmt_pkg::STAMP_W-1:0]      clock_now,
    input  logic [1:0]                       replace_mode,
    input  logic [2:0]                       ways_in_use,
    output hmt_pkg::entry_t [WAYS-1:0]       row_out,
    output hmt_pkg::result_t                 res
);
    import hmt_pkg::*;

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [COUNT_W-1:0] WAYS_C = COUNT_W'(WAYS);

    entry_t [WAYS-1:0]     ways;
    logic [COUNT_W-1:0]    count;
    logic [COUNT_W-1:0]    ins_rank;
    logic [COUNT_W-1:0]    limit;
    logic                  hit_found;
    logic [WW-1:0]         hit_way;
    logic [RANK_W-1:0]     hit_rank;
    logic                  vic_found;
    logic [WW-1:0]         vic_way;
    logic [RANK_W-1:0]     vic_rank;
    logic [STAMP_W-1:0]    vic_metric;
    logic [STAMP_W-1:0]    metric;
    logic                  evict_go;
    logic                  placed;

    always_comb begin
        ways = row_in;
        for (int w = 0; w < WAYS; w++) begin
            if (!row_ok) begin
                ways[w].valid = 1'b0;
            end
        end

        count = '0;
        for (int w = 0; w < WAYS; w++) begin
            count = count + COUNT_W'(ways[w].valid);
        end

        // oldest matching entry
        hit_found = 1'b0;
        hit_way   = '0;
        hit_rank  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (ways[w].valid && ways[w].hash == key_hash && ways[w].key == key_word &&
                (!hit_found || ways[w].rank < hit_rank)) begin
                hit_found = 1'b1;
                hit_way   = WW'(w);
                hit_rank  = ways[w].rank;
            end
        end

        // smallest metric, ties to the lower insertion rank
        vic_found  = 1'b0;
        vic_way    = '0;
        vic_rank   = '0;
        vic_metric = '0;
        for (int w = 0; w < WAYS; w++) begin
            case (replace_mode)
                MODE_LRU: metric = ways[w].last_use;
                MODE_LFU: metric = ways[w].hits;
                default:  metric = '0;
            endcase
            if (ways[w].valid && (!vic_found || metric < vic_metric ||
                (metric == vic_metric && ways[w].rank < vic_rank))) begin
                vic_found  = 1'b1;
                vic_way    = WW'(w);
                vic_rank   = ways[w].rank;
                vic_metric = metric;
            end
        end

        limit    = ({2'b00, ways_in_use} > WAYS_C) ? WAYS_C : {2'b00, ways_in_use};
        evict_go = (replace_mode != MODE_NEVER) && (limit != '0) && (count >= limit) &&
                   (count != '0);
        ins_rank = count;
        placed   = 1'b0;

        row_out        = ways;
        res.status     = ST_MISS;
        res.read_value = '0;

        case (opcode)
            OP_LOOKUP: begin
                if (hit_found) begin
                    res.status              = ST_HIT;
                    res.read_value          = ways[hit_way].value;
                    row_out[hit_way].last_use = clock_now;
                    if (ways[hit_way].hits != '1) begin
                        row_out[hit_way].hits = ways[hit_way].hits + 1'b1;
                    end
                end
            end
            OP_INSERT: begin
                res.status = ST_INSERTED;
                if (evict_go) begin
                    res.status = ST_EVICTED;
                    if (vic_found) begin
                        row_out[vic_way].valid = 1'b0;
                        for (int w = 0; w < WAYS; w++) begin
                            if (row_out[w].valid && row_out[w].rank > vic_rank) begin
                                row_out[w].rank = row_out[w].rank - 1'b1;
                            end
                        end
                        ins_rank = count - 1'b1;
                    end
                end else if (count >= WAYS_C) begin
                    res.status = ST_DROPPED;
                end
                if (res.status != ST_DROPPED) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (!placed && !row_out[w].valid) begin
                            placed            = 1'b1;
                            row_out[w].valid    = 1'b1;
                            row_out[w].hash     = key_hash;
                            row_out[w].key      = key_word;
                            row_out[w].value    = store_value;
                            row_out[w].last_use = clock_now;
                            row_out[w].hits     = '0;
                            row_out[w].rank     = ins_rank[RANK_W-1:0];
                        end
                    end
                    if (!placed) begin
                        res.status = ST_DROPPED;
                    end
                end
            end
            OP_CLEAR: begin
                res.status = ST_CLEARED;
            end
            default: begin
                res.status = ST_MISS;
            end
        endcase
    end
endmodule

FILE: rtl/hashed_memo_table_with_replacement.sv
// ----------------------------------------------------------------------------
// hashed_memo_table_with_replacement
// hashed set-associative memo table with fifo, lru and lfu replacement
// ----------------------------------------------------------------------------
// Each set of WAYS entries is one row of a single synchronous ram, so an
// item is one read-modify-write of its set: accept (ram read issued), the
// calc state to match and pick a victim, the write state to write the row
// back and load the result beat. The result beat is registered out of the
// write state, and the next input beat can be accepted once the sequencer
// is back in idle; a result beat still waiting holds the write state and
// with it the input. The registered ram read and the single write port
// set this order. Clear passes through the same states: a flip-flop per
// row marks whether the row holds data, and clear drops all of them at
// once, so no sweep of the ram is needed after reset or clear.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata; the user
// writes it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module hashed_memo_table_with_replacement #(
    parameter int MAX_INDEX_BITS = hmt_pkg::DEF_MAX_INDEX_BITS,
    parameter int WAYS           = hmt_pkg::DEF_WAYS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // key_hash[31:0], key_word[95:32], store_value[159:96]
    input  logic [7:0]   s_tuser,   // opcode[1:0], zero padding above
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // read_value[63:0]
    output logic [7:0]   m_tuser,   // status[2:0], zero padding above
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [3:0]   cfg_wdata
);
    import hmt_pkg::*;

    localparam int NSETS = 1 << MAX_INDEX_BITS;
    localparam int AW    = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int ROW_W = WAYS * $bits(entry_t);
    localparam logic [4:0] MAX_IB = 5'(MAX_INDEX_BITS);

    // configuration
    logic [1:0] replace_mode_reg;
    logic [2:0] ways_in_use_reg;
    logic [3:0] index_bits_reg;

    // control
    fsm_t                state_reg, state_next;
    logic [STAMP_W-1:0]  access_clock_reg;
    logic [NSETS-1:0]    row_ok_reg;

    // item being worked on
    opcode_t             op_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [AW-1:0]       set_reg;
    logic                ok_reg;

    // computed row and result
    entry_t [WAYS-1:0]   row_rd;
    entry_t [WAYS-1:0]   row_calc;
    entry_t [WAYS-1:0]   row_wr_reg;
    result_t             res_calc;
    result_t             res_reg;

    // result beat
    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  m_data_reg;
    status_t             m_status_reg;

    logic                s_accept;
    logic                out_free;
    logic                finish;
    logic                ram_we;
    logic [AW-1:0]       set_in;
    logic [4:0]          ib_sat;
    logic [ROW_W-1:0]    ram_rdata;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == FSM_WRITE) && out_free;
    assign ram_we   = finish && (op_reg == OP_LOOKUP || op_reg == OP_INSERT);

    // set index from the low hash bits, index_bits saturated
    always_comb begin
        ib_sat = ({1'b0, index_bits_reg} > MAX_IB) ? MAX_IB : {1'b0, index_bits_reg};
        for (int i = 0; i < AW; i++) begin
            set_in[i] = s_tdata[i] && (5'(i) < ib_sat);
        end
    end

    hmt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (row_wr_reg),
        .re    (s_accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    assign row_rd = ram_rdata;

    hmt_set_logic #(
        .WAYS (WAYS)
    ) u_set (
        .row_in       (row_rd),
        .row_ok       (ok_reg),
        .opcode       (op_reg),
        .key_hash     (hash_reg),
        .key_word     (key_reg),
        .store_value  (value_reg),
        .clock_now    (access_clock_reg),
        .replace_mode (replace_mode_reg),
        .ways_in_use  (ways_in_use_reg),
        .row_out      (row_calc),
        .res          (res_calc)
    );

    // sequencer: idle -> calc -> write (waits for a free result slot)
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = FSM_CALC;
                end
            end
            FSM_CALC: begin
                state_next = FSM_WRITE;
            end
            FSM_WRITE: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replace_mode_reg <= MODE_NEVER;
            ways_in_use_reg  <= 3'd0;
            index_bits_reg   <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_REPLACE_MODE: replace_mode_reg <= cfg_wdata[1:0];
                REG_WAYS_IN_USE:  ways_in_use_reg  <= cfg_wdata[2:0];
                REG_INDEX_BITS:   index_bits_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // item capture, row valid flags and access clock
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= opcode_t'(s_tuser[1:0]);
            hash_reg  <= s_tdata[31:0];
            key_reg   <= s_tdata[95:32];
            value_reg <= s_tdata[159:96];
            set_reg   <= set_in;
            ok_reg    <= row_ok_reg[set_in];
        end
        if (state_reg == FSM_CALC) begin
            row_wr_reg <= row_calc;
            res_reg    <= res_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg       <= '0;
            access_clock_reg <= '0;
        end else if (finish) begin
            if (op_reg == OP_CLEAR) begin
                row_ok_reg <= '0;
            end else if (ram_we) begin
                row_ok_reg[set_reg] <= 1'b1;
            end
            if (op_reg == OP_LOOKUP || op_reg == OP_INSERT) begin
                access_clock_reg <= access_clock_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_data_reg   <= res_reg.read_value;
            m_status_reg <= res_reg.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {5'b00000, m_status_reg};

    // a ram write only ever closes an item in the write state
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == FSM_WRITE)
        else $error("ram written outside write state");

    // an accepted beat always goes on to the match cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == FSM_CALC)
        else $error("accepted beat not followed by calc");

    // a new result beat only appears right after an item finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == FSM_WRITE)
        else $error("result beat without finished item");

    // the access clock only ever steps by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (access_clock_reg != $past(access_clock_reg)) |->
            (access_clock_reg == $past(access_clock_reg) + 1'b1))
        else $error("access clock jumped");

    // a hit never comes out of anything but a lookup
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_CALC && res_calc.status == ST_HIT) |-> op_reg == OP_LOOKUP)
        else $error("hit status on non-lookup");
endmodule

FILE: dv/hmt_checker.sv
// ----------------------------------------------------------------------------
// hmt_checker
// watches the input and result channels of the memo table, keeps its own copy
// of the table contents, and compares every result beat with the prediction
// ----------------------------------------------------------------------------
module hmt_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic [7:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [7:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [3:0]   cfg_wdata,
    output int           fail_count,
    output int           pending
);
    import hmt_pkg::*;

    localparam int NSETS = 1 << DEF_MAX_INDEX_BITS;
    localparam int NWAYS = DEF_WAYS;

    typedef struct {
        status_t     status;
        logic [63:0] value;
    } answer_t;

    logic [1:0]  mode_q;
    logic [2:0]  limit_q;
    logic [3:0]  ibits_q;
    bit          v_mem [NSETS][NWAYS];
    logic [31:0] h_mem [NSETS][NWAYS];
    logic [63:0] k_mem [NSETS][NWAYS];
    logic [63:0] d_mem [NSETS][NWAYS];
    logic [31:0] use_mem [NSETS][NWAYS];
    logic [31:0] hit_mem [NSETS][NWAYS];
    int          rank_mem [NSETS][NWAYS];
    logic [31:0] clk_cnt;
    answer_t     answers_q [$];

    function automatic int way_at_rank(int s, int r);
        for (int w = 0; w < NWAYS; w++)
            if (v_mem[s][w] && rank_mem[s][w] == r) return w;
        return NWAYS;
    endfunction

    // apply one beat to the table copy and return the answer it should give
    function automatic answer_t table_access(opcode_t op, logic [31:0] h, logic [63:0] k,
                                             logic [63:0] d);
        answer_t a;
        int ib, s, cnt, lim, w, best, vr;
        a.status = ST_MISS;
        a.value  = '0;
        ib = (ibits_q > DEF_MAX_INDEX_BITS) ? DEF_MAX_INDEX_BITS : ibits_q;
        s = h & ((1 << ib) - 1);
        cnt = 0;
        for (int i = 0; i < NWAYS; i++) if (v_mem[s][i]) cnt++;
        case (op)
            OP_LOOKUP: begin
                for (int r = 0; r < cnt; r++) begin
                    w = way_at_rank(s, r);
                    if (w < NWAYS && h_mem[s][w] == h && k_mem[s][w] == k) begin
                        a.status = ST_HIT;
                        a.value  = d_mem[s][w];
                        use_mem[s][w] = clk_cnt;
                        if (hit_mem[s][w] != '1) hit_mem[s][w]++;
                        break;
                    end
                end
                clk_cnt++;
            end
            OP_INSERT: begin
                lim = (limit_q > NWAYS) ? NWAYS : limit_q;
                a.status = ST_INSERTED;
                if (limit_q != 0 && mode_q != MODE_NEVER && cnt >= lim && cnt > 0) begin
                    best = way_at_rank(s, 0);
                    for (int r = 1; r < cnt; r++) begin
                        w = way_at_rank(s, r);
                        if (w >= NWAYS || best >= NWAYS) continue;
                        if (mode_q == MODE_LRU && use_mem[s][w] < use_mem[s][best]) best = w;
                        if (mode_q == MODE_LFU && hit_mem[s][w] < hit_mem[s][best]) best = w;
                    end
                    if (best < NWAYS) begin
                        vr = rank_mem[s][best];
                        v_mem[s][best] = 0;
                        for (int i = 0; i < NWAYS; i++)
                            if (v_mem[s][i] && rank_mem[s][i] > vr) rank_mem[s][i]--;
                        cnt--;
                    end
                    a.status = ST_EVICTED;
                end else if (cnt >= NWAYS) begin
                    a.status = ST_DROPPED;
                end
                if (a.status != ST_DROPPED) begin
                    w = NWAYS;
                    for (int i = NWAYS - 1; i >= 0; i--) if (!v_mem[s][i]) w = i;
                    if (w < NWAYS) begin
                        v_mem[s][w] = 1; h_mem[s][w] = h; k_mem[s][w] = k;
                        d_mem[s][w] = d; use_mem[s][w] = clk_cnt;
                        hit_mem[s][w] = 0; rank_mem[s][w] = cnt;
                    end else begin
                        a.status = ST_DROPPED;
                    end
                end
                clk_cnt++;
            end
            OP_CLEAR: begin
                for (int i = 0; i < NSETS; i++)
                    for (int j = 0; j < NWAYS; j++) v_mem[i][j] = 0;
                a.status = ST_CLEARED;
            end
            default: ;
        endcase
        return a;
    endfunction

    assign pending = answers_q.size();

    always @(posedge aclk) begin
        answer_t exp_a;
        if (!aresetn) begin
            mode_q <= MODE_NEVER;
            limit_q <= '0;
            ibits_q <= 4'd8;
            clk_cnt = '0;
            fail_count <= 0;
            for (int i = 0; i < NSETS; i++)
                for (int j = 0; j < NWAYS; j++) v_mem[i][j] = 0;
            answers_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_REPLACE_MODE: mode_q <= cfg_wdata[1:0];
                    REG_WAYS_IN_USE:  limit_q <= cfg_wdata[2:0];
                    REG_INDEX_BITS:   ibits_q <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                answers_q.insert(answers_q.size(),
                                 table_access(opcode_t'(s_tuser[1:0]), s_tdata[31:0],
                                              s_tdata[95:32], s_tdata[159:96]));
            if (m_tvalid && m_tready) begin
                if (answers_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got status %0d value %h",
                             $time, m_tuser[2:0], m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_a = answers_q.pop_front();
                    if (m_tuser[2:0] !== exp_a.status || m_tdata !== exp_a.value) begin
                        $display("%0t: mismatch, expected status %0d value %h, got %0d %h",
                                 $time, exp_a.status, exp_a.value, m_tuser[2:0], m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_hashed_memo_table_with_replacement.sv
// ----------------------------------------------------------------------------
// tb_hashed_memo_table_with_replacement
// drives lookups, inserts and clears through the memo table under several
// replacement settings and handshake idling patterns; a checker beside the
// block predicts each result beat and counts mismatches
// ----------------------------------------------------------------------------
module tb_hashed_memo_table_with_replacement;
    import hmt_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;   // key_hash[31:0], key_word[95:32], store_value[159:96]
    logic [7:0]   s_tuser = '0;   // opcode[1:0], zero padding above
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [63:0]  m_tdata;        // read_value[63:0]
    logic [7:0]   m_tuser;        // status[2:0], zero padding above
    logic         cfg_we = 0;
    logic [1:0]   cfg_addr = '0;
    logic [3:0]   cfg_wdata = '0;
    int           fail_count;
    int           pending;

    // percent of cycles each side idles; hold_off forces a long receiver stall
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_off = 0;
    longint cycles = 0;

    // small key pool so that lookups hit and sets fill up
    logic [31:0] pool_hash [16];
    logic [63:0] pool_key  [16];

    always #6 aclk = ~aclk;

    hashed_memo_table_with_replacement DUT (.*);

    hmt_checker u_checker (.*);

    // timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_hashed_memo_table_with_replacement failed");
            $finish;
        end
    end

    // receiver side: random stalls, or a forced hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
        end
    end

    // send one beat, idling at random beforehand; tvalid stays up after the
    // beat until the next call or an explicit idle drops it
    task automatic send_beat(opcode_t op, logic [31:0] h, logic [63:0] k, logic [63:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= {6'd0, op};
        s_tdata  <= {d, k, h};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [1:0] md, logic [2:0] lim, logic [3:0] ib);
        drain_results();
        write_reg(REG_REPLACE_MODE, {2'd0, md});
        write_reg(REG_WAYS_IN_USE, {1'b0, lim});
        write_reg(REG_INDEX_BITS, ib);
        cfg_we <= 0;
    endtask

    // mostly lookups and inserts over the key pool, some random noise
    task automatic random_beats(int n);
        int p, sel;
        opcode_t op;
        logic [63:0] k;
        logic [31:0] h;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(15);
            sel = $urandom_range(99);
            h = pool_hash[p];
            k = pool_key[p];
            if (sel < 45) op = OP_LOOKUP;
            else if (sel < 90) op = OP_INSERT;
            else if (sel < 92) op = OP_CLEAR;
            else if (sel < 94) op = OP_NONE;
            else begin
                op = opcode_t'($urandom_range(1));
                h = $urandom;
                k = {$urandom, $urandom};
            end
            // a lookup with the right hash but a wrong key now and then
            if (op == OP_LOOKUP && $urandom_range(9) == 0) k[$urandom_range(63)] ^= 1'b1;
            send_beat(op, h, k, {$urandom, $urandom});
        end
    endtask

    initial begin
        logic [63:0] ones;
        ones = '1;
        for (int i = 0; i < 16; i++) begin
            // few distinct sets, so sets fill; top bits random to exercise all bits
            pool_hash[i] = {$urandom, 2'b00} | ($urandom_range(3) << 8) | (i % 3);
            pool_key[i]  = {$urandom, $urandom};
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: never-delete mode at reset, fill a set, drop, duplicate
        send_beat(OP_LOOKUP, 32'h0, 64'h0, 64'h0);
        send_beat(OP_INSERT, 32'h0, 64'h0, ones);
        send_beat(OP_INSERT, 32'h0, 64'h0, 64'h5);
        send_beat(OP_LOOKUP, 32'h0, 64'h0, 64'h0);
        send_beat(OP_INSERT, '1, ones, ones);
        send_beat(OP_LOOKUP, '1, ones, 64'h0);
        send_beat(OP_INSERT, 32'h100, 64'h1, 64'h1);
        send_beat(OP_INSERT, 32'h200, 64'h2, 64'h2);
        send_beat(OP_INSERT, 32'h300, 64'h3, 64'h3);
        send_beat(OP_LOOKUP, 32'h300, 64'h3, 64'h0);
        send_beat(OP_NONE, 32'h0, 64'h0, 64'h0);
        send_beat(OP_CLEAR, 32'h0, 64'h0, 64'h0);
        send_beat(OP_LOOKUP, 32'h0, 64'h0, 64'h0);

        // fifo with a limit of one, and a limit above the way count
        set_config(MODE_FIFO, 3'd1, 4'd0);
        send_beat(OP_INSERT, 32'h7, 64'h7, 64'h70);
        send_beat(OP_INSERT, 32'h8, 64'h8, 64'h80);
        send_beat(OP_LOOKUP, 32'h7, 64'h7, 64'h0);
        send_beat(OP_LOOKUP, 32'h8, 64'h8, 64'h0);
        set_config(MODE_LRU, 3'd7, 4'd15);
        for (int i = 0; i < 5; i++) send_beat(OP_INSERT, 32'h9, i, i);
        send_beat(OP_LOOKUP, 32'h9, 64'h1, 64'h0);
        set_config(MODE_LFU, 3'd2, 4'd8);
        send_beat(OP_INSERT, 32'h9, 64'h9, 64'h9);

        // random phases over settings and idling patterns
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 49; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 49; end
                default: begin send_idle = 36; recv_idle = 36; end
            endcase
            set_config(ph[1:0] ^ ph[3:2], 3'($urandom_range(5)),
                       (ph == 5) ? 4'd15 : 4'($urandom_range(3)));
            if (ph == 3) begin
                fork
                    begin hold_off = 1; repeat (300) @(posedge aclk); hold_off = 0; end
                    begin random_beats(40); s_tvalid <= 0; end
                join
            end
            random_beats(110);
            if (ph == 8) drain_results();
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_hashed_memo_table_with_replacement passed");
        end else begin
            $display("tb_hashed_memo_table_with_replacement failed");
        end
        $finish;
    end

endmodule
